// ===== hw/rtl/cell_vote_bit_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Cell vote bit decoder: assertion macros
// Concurrent check macros clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef CELL_VOTE_BIT_DECODER_DEFINES_SVH
`define CELL_VOTE_BIT_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define CVBD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cell vote bit decoder check failed");
// Next-cycle implication.
`define CVBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cell vote bit decoder check failed");
`else
`define CVBD_ASSERT_NOW(lbl, ante, cons)
`define CVBD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/cvbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Cell vote bit decoder package
// Widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cvbd_pkg;

  localparam int MaxSamples  = 64;
  localparam int SampleAddrW = $clog2(MaxSamples);
  localparam int CountW      = SampleAddrW + 1;
  localparam int SampleW     = 8;
  localparam int ByteW       = 8;
  localparam int BitPosW     = 3;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 8;

  localparam logic [CfgIdxW-1:0] CFG_SAMPLES_PER_BIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BIT_THRESHOLD   = 2'd1;

  localparam logic [CountW-1:0]  SpbReset = CountW'(25);
  localparam logic [SampleW-1:0] ThrReset = SampleW'(100);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAND_RD,
    ST_CAND_CAP,
    ST_SCAN,
    ST_TALLY,
    ST_DECIDE
  } cvbd_state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/cvbd_ram.sv =====
// ----------------------------------------------------------------------------
// Cell vote bit decoder: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cvbd_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cell_vote_bit_decoder.sv =====
// Timing: a sample that does not close a cell is stored and the decoder stays idle;
// a closing sample of an n-sample cell starts a vote: per candidate one read, one
// capture, n compare reads and one tally on the single RAM port, then one decide.
// Throughput: one sample per cycle inside a cell; no sample is taken during a vote,
// and the decide of a byte's last bit stalls while an earlier output byte is unread.
// Reset: 25 samples per bit, threshold 100, counts clear; the sample RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "cell_vote_bit_decoder_defines.svh"

// ----------------------------------------------------------------------------
// Cell vote bit decoder
// Votes each cell of samples by its mode, thresholds it to a bit and packs
// eight bits LSB first into an output byte.
// ----------------------------------------------------------------------------
module cell_vote_bit_decoder import cvbd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                sample_valid_i,
  output logic                     sample_ready_o,
  input  wire logic [SampleW-1:0]  sample_i,
  output logic                     data_byte_valid_o,
  input  wire logic                data_byte_ready_i,
  output logic      [ByteW-1:0]    data_byte_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cvbd_state_e state_q, state_d;

  logic [CountW-1:0]      spb_q;
  logic [SampleW-1:0]     thr_q;
  logic [SampleAddrW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0]       bits_q, bits_d;
  logic [BitPosW-1:0]     pos_q, pos_d;
  logic [SampleAddrW-1:0] last_q, last_d;
  logic [SampleAddrW-1:0] cand_idx_q, cand_idx_d;
  logic [SampleAddrW-1:0] scan_idx_q, scan_idx_d;
  logic [SampleW-1:0]     cand_q, cand_d;
  logic [CountW-1:0]      match_q, match_d;
  logic [CountW-1:0]      best_cnt_q, best_cnt_d;
  logic [SampleW-1:0]     best_val_q, best_val_d;
  logic                   cmp_vld_q, cmp_vld_d;
  logic                   out_vld_q, out_vld_d;
  logic [ByteW-1:0]       out_byte_q, out_byte_d;

  logic [CountW-1:0]      eff_size;
  logic [CountW-1:0]      cnt_inc;
  logic                   cell_done;
  logic                   in_fire;
  logic                   hit;
  logic [CountW-1:0]      match_total;
  logic [ByteW-1:0]       bits_new;
  logic [SampleAddrW-1:0] rd_addr;
  logic [SampleW-1:0]     rd_data;

  assign cfg_ready_o       = 1'b1;
  assign sample_ready_o    = (state_q == ST_IDLE);
  assign data_byte_valid_o = out_vld_q;
  assign data_byte_o       = out_byte_q;
  assign in_fire           = sample_valid_i && sample_ready_o;

  // Clamp the cell size into 1..MaxSamples.
  always_comb begin
    eff_size = spb_q;
    if (spb_q == '0) begin
      eff_size = CountW'(1);
    end else if (spb_q > CountW'(MaxSamples)) begin
      eff_size = CountW'(MaxSamples);
    end
  end

  assign cnt_inc     = {1'b0, cnt_q} + CountW'(1);
  assign cell_done   = (cnt_inc >= eff_size);
  assign hit         = cmp_vld_q && (rd_data == cand_q);
  assign match_total = match_q + CountW'(hit);
  assign bits_new    = bits_q | (ByteW'(best_val_q > thr_q) << pos_q);
  assign rd_addr     = (state_q == ST_CAND_RD) ? cand_idx_q : scan_idx_q;

  cvbd_ram #(
    .Width (SampleW),
    .Depth (MaxSamples)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (cnt_q),
    .wdata_i (sample_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    bits_d     = bits_q;
    pos_d      = pos_q;
    last_d     = last_q;
    cand_idx_d = cand_idx_q;
    scan_idx_d = scan_idx_q;
    cand_d     = cand_q;
    match_d    = match_q;
    best_cnt_d = best_cnt_q;
    best_val_d = best_val_q;
    cmp_vld_d  = (state_q == ST_SCAN);
    out_vld_d  = out_vld_q && !data_byte_ready_i;
    out_byte_d = out_byte_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (cell_done) begin
            cnt_d      = '0;
            last_d     = SampleAddrW'(eff_size - CountW'(1));
            cand_idx_d = '0;
            best_cnt_d = '0;
            state_d    = ST_CAND_RD;
          end else begin
            cnt_d = cnt_inc[SampleAddrW-1:0];
          end
        end
      end
      ST_CAND_RD: begin
        state_d = ST_CAND_CAP;
      end
      ST_CAND_CAP: begin
        cand_d     = rd_data;
        scan_idx_d = '0;
        match_d    = '0;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        match_d = match_total;
        if (scan_idx_q == last_q) begin
          state_d = ST_TALLY;
        end else begin
          scan_idx_d = scan_idx_q + SampleAddrW'(1);
        end
      end
      ST_TALLY: begin
        // Strict compare keeps the earliest value on a tie.
        if (match_total > best_cnt_q) begin
          best_cnt_d = match_total;
          best_val_d = cand_q;
        end
        if (cand_idx_q == last_q) begin
          state_d = ST_DECIDE;
        end else begin
          cand_idx_d = cand_idx_q + SampleAddrW'(1);
          state_d    = ST_CAND_RD;
        end
      end
      ST_DECIDE: begin
        if (pos_q == '1) begin
          // Hold until the output register is free.
          if (!out_vld_d) begin
            out_vld_d  = 1'b1;
            out_byte_d = bits_new;
            bits_d     = '0;
            pos_d      = '0;
            state_d    = ST_IDLE;
          end
        end else begin
          bits_d  = bits_new;
          pos_d   = pos_q + BitPosW'(1);
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      spb_q     <= SpbReset;
      thr_q     <= ThrReset;
      cnt_q     <= '0;
      bits_q    <= '0;
      pos_q     <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      bits_q    <= bits_d;
      pos_q     <= pos_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SAMPLES_PER_BIT: spb_q <= cfg_data_i[CountW-1:0];
          CFG_BIT_THRESHOLD:   thr_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    cand_idx_q <= cand_idx_d;
    scan_idx_q <= scan_idx_d;
    cand_q     <= cand_d;
    match_q    <= match_d;
    best_cnt_q <= best_cnt_d;
    best_val_q <= best_val_d;
    out_byte_q <= out_byte_d;
  end

  `CVBD_ASSERT_NEXT(a_close_starts_vote, in_fire && cell_done, state_q == ST_CAND_RD)
  `CVBD_ASSERT_NOW(a_best_within_cell, state_q == ST_DECIDE,
                   (best_cnt_q != '0) && (best_cnt_q <= ({1'b0, last_q} + CountW'(1))))
  `CVBD_ASSERT_NOW(a_byte_load_clears, $rose(data_byte_valid_o),
                   (pos_q == '0) && (bits_q == '0))

endmodule

`default_nettype wire
